FILE: rtl/dsc_pkg.sv
// package for the double to s31.32 converter: constants and shared types
package dsc_pkg;

    localparam int FRAC_BITS = 32;
    localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
    localparam logic [62:0] MAX_MAG = {63{1'b1}};

    typedef enum logic {
        CMD_ENCODE = 1'b0,
        CMD_DECODE = 1'b1
    } cmd_t;

endpackage

FILE: rtl/dsc_encode.sv
// encode path: ieee double bits to sign-magnitude fixed point
module dsc_encode (
    input  logic [63:0] operand,
    output logic [63:0] result
);

    logic [10:0] expf;
    logic [51:0] mant;
    logic [52:0] m;
    logic        neg;
    logic signed [12:0] sh;
    logic [6:0]  r;
    logic [62:0] mag;
    logic [115:0] wide;
    logic [52:0] shr;
    logic        rbit;

    always_comb
    begin
        expf = operand[62:52];
        mant = operand[51:0];
        neg = operand[63] && !(expf == 11'd0 && mant == 52'd0);
        if (expf == 11'd0)
        begin
            m = {1'b0, mant};
            sh = 13'(-1074 + dsc_pkg::FRAC_BITS);
        end
        else
        begin
            m = {1'b1, mant};
            sh = $signed({2'b00, expf}) - 13'sd1075 + 13'(dsc_pkg::FRAC_BITS);
        end
        r = 7'd0;
        wide = '0;
        shr = '0;
        rbit = 1'b0;
        if (m == 53'd0)
            mag = '0;
        else if (sh >= 0)
        begin
            wide = {63'd0, m} << sh[6:0];
            if (sh > 13'sd63 || wide[115:63] != '0)
                mag = dsc_pkg::MAX_MAG;
            else
                mag = wide[62:0];
        end
        else
        begin
            if (sh < -13'sd53)
                mag = '0;
            else
            begin
                r = 7'(-sh);
                shr = m >> r;
                rbit = m[6'(r - 7'd1)];
                mag = 63'(shr) + 63'(rbit);
            end
        end
        if (expf == 11'h7FF)
            mag = dsc_pkg::MAX_MAG;
        if (expf == 11'h7FF && mant != 52'd0)
            result = '0;
        else
            result = {neg, mag};
    end

endmodule

FILE: rtl/dsc_decode.sv
// decode path: sign-magnitude fixed point to ieee double bits
module dsc_decode (
    input  logic [63:0] operand,
    output logic [63:0] result
);

    logic [62:0] mag;
    logic [5:0]  p;
    logic [62:0] norm;
    logic [53:0] q;
    logic        guard;
    logic        sticky;
    logic [6:0]  pe;
    logic [10:0] expf;

    always_comb
    begin
        mag = operand[62:0];
        p = '0;
        for (int i = 0; i < 63; i++)
        begin
            if (mag[i])
                p = 6'(i);
        end
        // left-justify so the leading one sits at bit 62
        norm = mag << (6'd62 - p);
        guard = norm[9];
        sticky = norm[8:0] != '0;
        q = {1'b0, norm[62:10]};
        if (guard && (sticky || norm[10]))
            q = q + 54'd1;
        pe = {1'b0, p};
        if (q[53])
        begin
            q = q >> 1;
            pe = pe + 7'd1;
        end
        expf = 11'(pe) + 11'd1023 - 11'(dsc_pkg::FRAC_BITS);
        if (mag == '0)
            result = {operand[63], 63'd0};
        else
            result = {operand[63], expf, q[51:0]};
    end

endmodule

FILE: rtl/double_s31_32_converter_top.sv
// top level of the double to s31.32 converter
// path from input beat to result beat: input register, then result register
// throughput: one beat per cycle, sustained while result side is not stalled
// in_stall rises combinationally from out_stall once both registers hold a beat
// reset clears all valid flags; payload registers are not reset
module double_s31_32_converter_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [63:0] operand,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] result
);

    logic        a_valid_reg;
    logic        a_cmd_reg;
    logic [63:0] a_op_reg;
    logic        r_valid_reg;
    logic [63:0] r_data_reg;
    logic [63:0] enc_res;
    logic [63:0] dec_res;
    logic        r_free;
    logic        a_free;

    assign r_free = !r_valid_reg || !out_stall;
    assign a_free = !a_valid_reg || r_free;
    assign in_stall = !a_free;

    dsc_encode u_enc (.operand(a_op_reg), .result(enc_res));
    dsc_decode u_dec (.operand(a_op_reg), .result(dec_res));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_free)
                a_valid_reg <= in_valid;
            if (r_free)
                r_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_free && in_valid)
        begin
            a_cmd_reg <= cmd;
            a_op_reg <= operand;
        end
        if (r_free && a_valid_reg)
            r_data_reg <= (dsc_pkg::cmd_t'(a_cmd_reg) == dsc_pkg::CMD_DECODE) ? dec_res : enc_res;
    end

    assign out_valid = r_valid_reg;
    assign result = r_data_reg;

endmodule

FILE: rtl/dsc_checker.sv
// port checker for the converter top level and its bind
module dsc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] result
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result))
        else $error("result changed under stall");

    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_stall |=> ##1 out_valid)
        else $error("missing result beat");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

endmodule

bind double_s31_32_converter_top dsc_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .result(result)
);
